/* design/sdk_pkg.sv */
`timescale 1ns / 1ps

package sdk_pkg;

    localparam int KEY_W     = 8;
    localparam int OUT_IDX_W = 6;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_LOAD    = 6'b000001,
        S_PASS    = 6'b000010,
        S_SCAN    = 6'b000100,
        S_FLUSH   = 6'b001000,
        S_EMIT_RD = 6'b010000,
        S_EMIT_LD = 6'b100000
    } t_state;

endpackage

/* design/stable_descending_key_index_sort.sv */
`timescale 1ns / 1ps
// Loading: a run of n entries loads at one item per cycle; after the last item the
//   input is held off while the bubble sort passes (S_PASS, S_SCAN, S_FLUSH) run.
// Results: each result needs an S_EMIT_RD read and an S_EMIT_LD load, bounded by the
//   single read port of the entry memory, which also serves each sort pass.
// Reset: synchronous, active low; clears the sequencer, fill count, overflow flag and
//   output valid. The entry memory is not cleared; only written entries are read.
module stable_descending_key_index_sort #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sdk_pkg::KEY_W-1:0]     i_win_count,
    input  logic                          i_last_item,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sdk_pkg::OUT_IDX_W-1:0] o_entry_index,
    output logic [sdk_pkg::KEY_W-1:0]     o_sorted_count,
    output logic                          o_last_result,
    output logic                          o_overflow
);
    import sdk_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;  // entry address
    localparam int CW = $clog2(MAX_ENTRIES + 1);                        // fill count
    localparam int EW = KEY_W + AW;                                     // key over index

    // Entry memory: key in the upper bits, arrival index in the lower bits.
    logic [EW-1:0] r_mem [MAX_ENTRIES];
    logic [EW-1:0] r_q;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill;       // entries loaded in this run
    logic          r_ovf;        // items dropped in this run
    logic [CW-1:0] r_n;          // run length frozen at the end of loading
    logic [AW-1:0] r_lim;        // last position of the current pass
    logic [AW-1:0] r_pos;        // position of the entry now on r_q
    logic [AW-1:0] r_rd_addr;    // next address to read during a scan
    logic [AW-1:0] r_k;          // rank being emitted
    logic [EW-1:0] r_carry;      // entry bubbling to the right in this pass

    logic          r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic [KEY_W-1:0]     r_out_key;
    logic          r_out_last;
    logic          r_out_ovf;

    logic          in_acc;
    logic          room;
    logic [CW-1:0] run_len;
    logic          carry_lt;
    logic          out_free;
    logic          emit_last;

    assign o_in_ready = r_state[0];           // S_LOAD bit
    assign in_acc     = i_in_valid && o_in_ready;
    assign room       = r_fill < CW'(MAX_ENTRIES);
    // Length of the run once the current item is counted; fill never exceeds capacity.
    assign run_len    = room ? r_fill + CW'(1) : r_fill;
    // Strict less-than keeps equal keys in arrival order.
    assign carry_lt   = r_carry[EW-1 -: KEY_W] < r_q[EW-1 -: KEY_W];
    assign out_free   = !r_out_valid || i_out_ready;
    assign emit_last  = (CW'(r_k) + CW'(1)) == r_n;

    // Memory port control and next state
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = '0;
        mem_re  = 1'b0;
        mem_ra  = r_rd_addr;
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                // Write the item at the fill position, tagged with that position.
                if (in_acc && room) begin
                    mem_we = 1'b1;
                    mem_wa = r_fill[AW-1:0];
                    mem_wd = {i_win_count, r_fill[AW-1:0]};
                end
                if (in_acc && i_last_item) begin
                    n_state = (run_len == CW'(1)) ? S_EMIT_RD : S_PASS;
                end
            end
            S_PASS: begin
                // Open a pass at the head of the store.
                mem_re  = 1'b1;
                mem_ra  = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // Settle position r_pos-1: the larger (or earlier on a tie) stays left.
                if (r_pos != '0) begin
                    mem_we = 1'b1;
                    mem_wa = r_pos - AW'(1);
                    mem_wd = carry_lt ? r_q : r_carry;
                end
                if (r_pos == r_lim) begin
                    n_state = S_FLUSH;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_FLUSH: begin
                // Drop the carried entry into the pass's last position.
                mem_we  = 1'b1;
                mem_wa  = r_lim;
                mem_wd  = r_carry;
                n_state = (r_lim == AW'(1)) ? S_EMIT_RD : S_PASS;
            end
            S_EMIT_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_k;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    n_state = emit_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_q <= r_mem[mem_ra];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOAD && in_acc) begin
                if (room) begin
                    r_fill <= r_fill + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            // Start an empty run once the last result is loaded.
            if (r_state == S_EMIT_LD && out_free && emit_last) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end
            if (r_state == S_EMIT_LD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sort and emit datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                r_n   <= run_len;
                r_lim <= AW'(run_len - CW'(1));
                r_k   <= '0;
            end
            S_PASS: begin
                r_pos     <= '0;
                r_rd_addr <= AW'(1);
            end
            S_SCAN: begin
                // Carry the smaller entry on; on a tie the later one moves right.
                if (r_pos == '0 || !carry_lt) begin
                    r_carry <= r_q;
                end
                if (r_pos != r_lim) begin
                    r_pos     <= r_pos + AW'(1);
                    r_rd_addr <= r_rd_addr + AW'(1);
                end
            end
            S_FLUSH: begin
                r_lim <= r_lim - AW'(1);
            end
            S_EMIT_RD: begin
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    r_out_idx  <= OUT_IDX_W'(r_q[AW-1:0]);
                    r_out_key  <= r_q[EW-1 -: KEY_W];
                    r_out_last <= emit_last;
                    r_out_ovf  <= r_ovf;
                    r_k        <= r_k + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_entry_index  = r_out_idx;
    assign o_sorted_count = r_out_key;
    assign o_last_result  = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

/* test/tb_stable_descending_key_index_sort.sv */
`timescale 1ns / 1ps

// One expected result: the entry at one rank of a sorted run
typedef struct packed {
    bit [5:0] index;
    bit [7:0] count;
    bit       last;
    bit       ovf;
} t_rank;

// Tracks the entries of the current run and holds the ranked results still owed by the block
class sort_scoreboard;
    localparam int CAP = 32;

    bit [7:0]    run_keys[CAP];
    bit [5:0]    run_pos[CAP];
    int unsigned fill;
    bit          dropped;
    t_rank       pending[$];
    int unsigned noted;
    int unsigned errors;

    function new();
        fill    = 0;
        dropped = 0;
        noted   = 0;
        errors  = 0;
    endfunction

    // Load one accepted item; on the last item of a run, rank the run and queue its results
    function void note_item(bit [7:0] key, bit last);
        bit [7:0] k[CAP];
        bit [5:0] p[CAP];
        bit [7:0] tk;
        bit [5:0] tp;
        int       n;
        t_rank    r;
        noted++;
        if (fill < CAP) begin
            run_keys[fill] = key;
            run_pos[fill]  = fill[5:0];
            fill++;
        end else begin
            dropped = 1;
        end
        if (!last) return;
        n = fill;
        for (int i = 0; i < n; i++) begin
            k[i] = run_keys[i];
            p[i] = run_pos[i];
        end
        // swap on strict less-than only, so ties keep arrival order
        for (int ps = 0; ps + 1 < n; ps++) begin
            for (int j = 0; j + 1 < n - ps; j++) begin
                if (k[j] < k[j+1]) begin
                    tk = k[j]; k[j] = k[j+1]; k[j+1] = tk;
                    tp = p[j]; p[j] = p[j+1]; p[j+1] = tp;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            r.index = p[i];
            r.count = k[i];
            r.last  = (i == n - 1);
            r.ovf   = dropped;
            pending = {pending, r};
        end
        fill    = 0;
        dropped = 0;
    endfunction

    function void check_result(bit [5:0] index, bit [7:0] count, bit last, bit ovf);
        t_rank e;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, got index %0d count %0d last %0b ovf %0b",
                     $time, index, count, last, ovf);
            return;
        end
        e = pending.pop_front();
        if (e.index != index || e.count != count || e.last != last || e.ovf != ovf) begin
            errors++;
            $display("%0t: mismatch, expected index %0d count %0d last %0b ovf %0b",
                     $time, e.index, e.count, e.last, e.ovf);
            $display("%0t:           got index %0d count %0d last %0b ovf %0b",
                     $time, index, count, last, ovf);
        end
    endfunction
endclass

module tb_stable_descending_key_index_sort;
    import sdk_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int TARGET      = 430;
    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 600;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [KEY_W-1:0]     i_win_count   = '0;
    logic                 i_last_item   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [OUT_IDX_W-1:0] o_entry_index;
    logic [KEY_W-1:0]     o_sorted_count;
    logic                 o_last_result;
    logic                 o_overflow;

    sort_scoreboard sb = new();
    int unsigned    cycles = 0;
    int unsigned    sent   = 0;

    // Directed runs: bit 8 marks the last item of a run, bits 7:0 hold the win count.
    // Covers a lone minimum, a lone maximum, an all-tie run, an ascending run that
    // must fully reverse, mixed ties, and alternating extremes.
    logic [8:0] directed [21] = '{
        9'h100,
        9'h1FF,
        9'h005, 9'h005, 9'h105,
        9'h001, 9'h002, 9'h003, 9'h104,
        9'h0C8, 9'h064, 9'h0C8, 9'h000, 9'h0FF, 9'h164,
        9'h0FF, 9'h000, 9'h0FF, 9'h100,
        9'h009, 9'h109
    };

    stable_descending_key_index_sort #(
        .MAX_ENTRIES(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_win_count    (i_win_count),
        .i_last_item    (i_last_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_entry_index  (o_entry_index),
        .o_sorted_count (o_sorted_count),
        .o_last_result  (o_last_result),
        .o_overflow     (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sample both handshakes on the edge that completes them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_item(i_win_count, i_last_item);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_entry_index, o_sorted_count, o_last_result, o_overflow);
        end
    end

    // Result side: stretches of steady, sparse or no acceptance, plus one long
    // hold-off in the middle of the random part so the block backs up into its input
    initial begin : result_sink
        int  mode;
        int  span;
        int  hold_left;
        bit  held;
        mode      = 0;
        span      = 0;
        hold_left = 0;
        held      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!held && sb.noted >= 150) begin
                held      = 1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
                    span = (mode == 3) ? $urandom_range(20, 60) : $urandom_range(20, 80);
                end
                span--;
                unique case (mode)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        i_out_ready <= ($urandom_range(0, 2) == 0);
                    end
                    default: begin
                        i_out_ready <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic [7:0] key, input logic last);
        i_in_valid  <= 1'b1;
        i_win_count <= key;
        i_last_item <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    // Drop valid over the idle gap when n is above zero; leave it up when n is zero so the next item follows directly
    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    initial begin : stimulus
        int         len;
        int         r;
        int         runs;
        bit         burst;
        bit         ties;
        logic [7:0] key;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_item(directed[i][7:0], directed[i][8]);
            idle_gap(pick_gap());
        end

        // Random runs: mostly short, some long up to capacity, a few past capacity
        // so that items are dropped and the closing item itself may be dropped
        runs = 0;
        while (sent < TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 65)
                len = $urandom_range(1, 8);
            else if (r < 80)
                len = $urandom_range(9, CAPACITY - 1);
            else if (r < 88)
                len = CAPACITY;
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
            burst = ($urandom_range(0, 3) == 0);
            ties  = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < len; i++) begin
                key = ties ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
                send_item(key, i == len - 1);
                if (i == len - 1 && runs == 6)
                    drain();
                else if (!burst)
                    idle_gap(pick_gap());
            end
            runs++;
        end

        // wait one edge first so the final item is noted before the queue is checked
        drain();
        // catch any stray result after the last expected one
        repeat (100) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
design/sdk_pkg.sv
design/stable_descending_key_index_sort.sv
test/tb_stable_descending_key_index_sort.sv
